>>> rtl/fga_pkg.sv
// Shared types, constants and fuzzification functions of the fuzzy gain adjuster.
`default_nettype none

package fga_pkg;

    localparam int INPUT_FRAC_BITS = 12;
    localparam int GRADE_FRAC_BITS = 12;

    localparam int IN_W  = 16;
    localparam int OUT_W = 16;
    // holds +-3 units at the widest input fraction plus a 16-bit input
    localparam int XW    = 18;
    localparam int DW    = INPUT_FRAC_BITS + 2;
    localparam int GW    = GRADE_FRAC_BITS + 1;
    localparam int NG    = 7;
    localparam int IDX_W = 3;
    localparam int WG_W  = 13;

    // defuzzification: |value| * 2^15 / (20 * 2^G), rounded half away from zero
    localparam int MW        = GRADE_FRAC_BITS + 3;
    localparam int NW        = MW + 16;
    localparam int QW        = 17;
    localparam int ROUND_ADD = 10 * (1 << GRADE_FRAC_BITS);
    localparam int RECIP5    = 52429;
    localparam int RECIP5_SH = 18;
    localparam int PW        = QW + 16;

    typedef logic [GW-1:0] grade_t;
    typedef grade_t [NG-1:0] grade_vec_t;
    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [2:0] {
        LAB_NB = 3'd0,
        LAB_NM = 3'd1,
        LAB_NS = 3'd2,
        LAB_ZO = 3'd3,
        LAB_PS = 3'd4,
        LAB_PM = 3'd5,
        LAB_PB = 3'd6
    } label_t;

    localparam grade_t GRADE_ONE = grade_t'(1) << GRADE_FRAC_BITS;

    // rows: error grade, columns: error change grade
    localparam label_t RULE_TAB [0:NG-1][0:NG-1] = '{
        '{LAB_PB, LAB_PB, LAB_PM, LAB_PS, LAB_PS, LAB_ZO, LAB_ZO},
        '{LAB_PB, LAB_PB, LAB_PM, LAB_PS, LAB_PS, LAB_ZO, LAB_NS},
        '{LAB_PM, LAB_PM, LAB_PM, LAB_PS, LAB_ZO, LAB_NS, LAB_NS},
        '{LAB_PM, LAB_PM, LAB_PS, LAB_ZO, LAB_NS, LAB_NM, LAB_NM},
        '{LAB_PS, LAB_PS, LAB_ZO, LAB_NS, LAB_NS, LAB_NM, LAB_NM},
        '{LAB_PS, LAB_ZO, LAB_NS, LAB_NM, LAB_NM, LAB_NM, LAB_NB},
        '{LAB_ZO, LAB_ZO, LAB_NM, LAB_NM, LAB_NM, LAB_NB, LAB_NB}
    };

    function automatic logic signed [XW-1:0] unit_of(input int k);
        return XW'(k * (1 << INPUT_FRAC_BITS));
    endfunction

    // slopes are one or two units wide, so the divide is a shift
    function automatic grade_t slope_grade(input logic signed [XW-1:0] offset,
                                           input logic wide);
        logic [DW+GRADE_FRAC_BITS-1:0] n;
        n = {offset[DW-1:0], {GRADE_FRAC_BITS{1'b0}}};
        if (wide)
            return GW'(n >> (INPUT_FRAC_BITS + 1));
        return GW'(n >> INPUT_FRAC_BITS);
    endfunction

    function automatic grade_t tri_grade(input logic signed [XW-1:0] x,
                                         input int a, input int b, input int c);
        if (x <= unit_of(a) || x > unit_of(c))
            return '0;
        if (x <= unit_of(b))
            return slope_grade(x - unit_of(a), (b - a) == 2);
        return slope_grade(unit_of(c) - x, (c - b) == 2);
    endfunction

    function automatic grade_t trap_left(input logic signed [XW-1:0] x,
                                         input int a, input int b);
        if (x <= unit_of(a))
            return GRADE_ONE;
        if (x <= unit_of(b))
            return slope_grade(unit_of(b) - x, (b - a) == 2);
        return '0;
    endfunction

    function automatic grade_t trap_right(input logic signed [XW-1:0] x,
                                          input int a, input int b);
        if (x <= unit_of(a))
            return '0;
        if (x < unit_of(b))
            return slope_grade(x - unit_of(a), (b - a) == 2);
        return GRADE_ONE;
    endfunction

    function automatic grade_vec_t fuzzify(input logic signed [IN_W-1:0] v);
        logic signed [XW-1:0] x;
        grade_vec_t g;
        x = XW'(v);
        g[LAB_NB] = trap_left(x, -3, -1);
        g[LAB_NM] = tri_grade(x, -3, -2, 0);
        g[LAB_NS] = tri_grade(x, -3, -1, 1);
        g[LAB_ZO] = tri_grade(x, -2, 0, 2);
        g[LAB_PS] = tri_grade(x, -1, 1, 3);
        g[LAB_PM] = tri_grade(x, 0, 2, 3);
        g[LAB_PB] = trap_right(x, 1, 3);
        return g;
    endfunction

endpackage

`default_nettype wire

>>> rtl/fuzzy_gain_adjust.sv
// Fuzzy self-tuning of a proportional gain: top level with a five-register pipeline.
//
// Takes one (error_value, error_change) pair per item and returns one item with the gain
// delta, the winning min-combined grade and the chosen rule label. Five register stages
// (input, grades, per-row winners, final selection, output); an item can be accepted every
// cycle unless the pipeline is full and the output stalled. Each stage moves on when it is
// empty or the stage after it moves, so bubbles are filled and a stalled output still lets
// new items enter until the pipeline is full. No state is kept between items.
`default_nettype none

module fuzzy_gain_adjust
    import fga_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic signed [IN_W-1:0] error_value,
    input  wire logic signed [IN_W-1:0] error_change,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic signed [OUT_W-1:0]     gain_delta,
    output logic [WG_W-1:0]             winning_grade,
    output logic [2:0]                  rule_label
);

    logic out_en, s4_en, s3_en, s2_en, s1_en;

    logic                   s1_valid_reg;
    logic signed [IN_W-1:0] s1_err_reg, s1_chg_reg;

    logic       s2_valid_reg;
    grade_vec_t s2_ge_reg, s2_gc_reg;
    grade_vec_t s2_ge_next, s2_gc_next;

    logic   s3_valid_reg;
    grade_t s3_row_best_reg [NG];
    idx_t   s3_row_col_reg  [NG];
    grade_t s3_row_best_next [NG];
    idx_t   s3_row_col_next  [NG];

    logic          s4_valid_reg;
    grade_t        s4_best_reg, s4_best_next;
    label_t        s4_label_reg, s4_label_next;
    logic          s4_neg_reg, s4_neg_next;
    logic [QW-1:0] s4_quot_reg, s4_quot_next;

    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] gain_delta_reg, gain_delta_next;
    logic [WG_W-1:0]         winning_grade_reg;
    label_t                  rule_label_reg;

    assign out_en   = !out_valid_reg || out_ready;
    assign s4_en    = !s4_valid_reg || out_en;
    assign s3_en    = !s3_valid_reg || s4_en;
    assign s2_en    = !s2_valid_reg || s3_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;

    assign out_valid     = out_valid_reg;
    assign gain_delta    = gain_delta_reg;
    assign winning_grade = winning_grade_reg;
    assign rule_label    = rule_label_reg;

    always_comb
    begin
        s2_ge_next = fuzzify(s1_err_reg);
        s2_gc_next = fuzzify(s1_chg_reg);
    end

    // first maximum of each row, strict greater keeps the earliest column
    always_comb
    begin
        grade_t w;
        for (int i = 0; i < NG; i++)
        begin
            s3_row_best_next[i] = (s2_ge_reg[i] < s2_gc_reg[0]) ? s2_ge_reg[i] : s2_gc_reg[0];
            s3_row_col_next[i]  = '0;
            for (int j = 1; j < NG; j++)
            begin
                w = (s2_ge_reg[i] < s2_gc_reg[j]) ? s2_ge_reg[i] : s2_gc_reg[j];
                if (w > s3_row_best_next[i])
                begin
                    s3_row_best_next[i] = w;
                    s3_row_col_next[i]  = IDX_W'(j);
                end
            end
        end
    end

    always_comb
    begin
        idx_t          bi, bj;
        logic [MW-1:0] mag;
        logic [NW-1:0] num;
        s4_best_next = s3_row_best_reg[0];
        bi           = '0;
        bj           = s3_row_col_reg[0];
        for (int i = 1; i < NG; i++)
        begin
            if (s3_row_best_reg[i] > s4_best_next)
            begin
                s4_best_next = s3_row_best_reg[i];
                bi           = IDX_W'(i);
                bj           = s3_row_col_reg[i];
            end
        end
        s4_label_next = RULE_TAB[bi][bj];

        // magnitude of value*20 in grade units
        mag         = '0;
        s4_neg_next = 1'b0;
        case (s4_label_next)
            LAB_NB:
            begin
                mag         = (MW'(2) << GRADE_FRAC_BITS) + (MW'(s4_best_next) << 2);
                s4_neg_next = 1'b1;
            end
            LAB_NM:
            begin
                mag         = (MW'(3) << GRADE_FRAC_BITS) + MW'(s4_best_next);
                s4_neg_next = 1'b1;
            end
            LAB_NS:
            begin
                mag         = MW'(2) << GRADE_FRAC_BITS;
                s4_neg_next = 1'b1;
            end
            LAB_ZO:  mag = '0;
            LAB_PS:  mag = MW'(2) << GRADE_FRAC_BITS;
            LAB_PM:  mag = (MW'(3) << GRADE_FRAC_BITS) + MW'(s4_best_next);
            LAB_PB:  mag = (MW'(2) << GRADE_FRAC_BITS) + (MW'(s4_best_next) << 2);
            default: mag = '0;
        endcase
        num          = {mag, 16'b0} >> 1;
        num          = num + NW'(ROUND_ADD);
        s4_quot_next = QW'(num >> (GRADE_FRAC_BITS + 2));
    end

    // remaining divide by 5 as a reciprocal multiply, exact below 2^18
    always_comb
    begin
        logic [PW-1:0]    prod;
        logic [OUT_W-1:0] q;
        prod = PW'(s4_quot_reg) * PW'(RECIP5);
        q    = OUT_W'(prod >> RECIP5_SH);
        gain_delta_next = s4_neg_reg ? $signed(OUT_W'(0) - q) : $signed(q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= in_valid;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
            if (s3_en)
                s3_valid_reg <= s2_valid_reg;
            if (s4_en)
                s4_valid_reg <= s3_valid_reg;
            if (out_en)
                out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && in_valid)
        begin
            s1_err_reg <= error_value;
            s1_chg_reg <= error_change;
        end
        if (s2_en && s1_valid_reg)
        begin
            s2_ge_reg <= s2_ge_next;
            s2_gc_reg <= s2_gc_next;
        end
        if (s3_en && s2_valid_reg)
        begin
            s3_row_best_reg <= s3_row_best_next;
            s3_row_col_reg  <= s3_row_col_next;
        end
        if (s4_en && s3_valid_reg)
        begin
            s4_best_reg  <= s4_best_next;
            s4_label_reg <= s4_label_next;
            s4_neg_reg   <= s4_neg_next;
            s4_quot_reg  <= s4_quot_next;
        end
        if (out_en && s4_valid_reg)
        begin
            gain_delta_reg    <= gain_delta_next;
            winning_grade_reg <= WG_W'(s4_best_reg);
            rule_label_reg    <= s4_label_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_grade_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> s4_best_reg <= GRADE_ONE)
        else $error("winning grade above one");

    a_zo_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && rule_label_reg == LAB_ZO |-> gain_delta_reg == '0)
        else $error("ZO label with nonzero gain delta");

    a_neg_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (rule_label_reg == LAB_NB || rule_label_reg == LAB_NM ||
                          rule_label_reg == LAB_NS) |-> gain_delta_reg[OUT_W-1])
        else $error("negative label with nonnegative gain delta");

    a_pos_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (rule_label_reg == LAB_PS || rule_label_reg == LAB_PM ||
                          rule_label_reg == LAB_PB)
        |-> !gain_delta_reg[OUT_W-1] && gain_delta_reg != '0)
        else $error("positive label with nonpositive gain delta");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid_reg && !out_ready && s4_valid_reg && s3_valid_reg)
        else $error("input stalled while the pipeline has room");
`endif

endmodule

`default_nettype wire
